// ----- hdl/mfsq_pkg.sv -----
// Package for the multi-queue FIFO with shortest-queue selection.
// Request and status codes, controller states, command and status bundles.
// No dependencies.
package mfsq_pkg;

  localparam int unsigned REQ_BITS    = 2;
  localparam int unsigned QIDX_BITS   = 3;
  localparam int unsigned STATUS_BITS = 3;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_ENQUEUE  = 2'd0,
    REQ_SERVE    = 2'd1,
    REQ_CHECKOUT = 2'd2,
    REQ_QUERY    = 2'd3
  } req_type_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK        = 3'd0,
    STAT_INVALID   = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_MIN,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic    load;
    logic    push;
    logic    pop;
    logic    scan_next;
    logic    min_start;
    logic    min_step;
    logic    set_status;
    status_e status_code;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    req_type_e req;
    logic      qidx_ok;
    logic      occ_zero;
    logic      occ_full;
    logic      head_match;
    logic      sel_last;
    logic      out_busy;
  } dp_status_t;

endpackage

// ----- hdl/multi_fifo_shortest_queue_core.sv -----
// Top level of the multi-queue FIFO with shortest-queue selection.
// Joins the controller (mfsq_ctrl) and the datapath (mfsq_datapath).
// Depends on mfsq_pkg.
//
// Usage: a request beat (req_type_i, queue_index_i, ident_i) is taken when
// in_valid_i is high and in_stall_o is low. Each request yields exactly one
// result beat (status_o, served_ident_o, served_queue_o, best_queue_o,
// best_count_o), taken when out_valid_o is high and out_stall_i is low.
// One request is in work at a time; in_stall_o is low only in idle.
// Each request is decoded; a serve of a valid, non-empty queue then reads and
// checks its head, and a checkout reads and compares queue heads in turn until
// a match or the last queue. Every request then scans all NUM_QUEUES counts
// for the shortest queue; the next beat is taken only back in idle.
// The checkout head scan reads one queue head at a time through the
// single registered memory read port, and the shortest-queue search steps
// through one count per cycle. The result sits in an output register, so
// the next request is accepted while a result waits; a stalled receiver
// holds that result and the following request stays in its final state.
// Reset empties every queue, clears pointers and counts and drops any
// pending result; the identifier memory needs no clearing.
module multi_fifo_shortest_queue_core #(
  parameter int unsigned NUM_QUEUES  = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [mfsq_pkg::REQ_BITS-1:0]            req_type_i,
  input  logic [mfsq_pkg::QIDX_BITS-1:0]           queue_index_i,
  input  logic [ID_BITS-1:0]                       ident_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [mfsq_pkg::STATUS_BITS-1:0]         status_o,
  output logic [ID_BITS-1:0]                       served_ident_o,
  output logic [$clog2(NUM_QUEUES)-1:0]            served_queue_o,
  output logic [$clog2(NUM_QUEUES)-1:0]            best_queue_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]         best_count_o
);
  import mfsq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  mfsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  mfsq_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .dp_status_o    (dp_status),
    .req_type_i     (req_type_i),
    .queue_index_i  (queue_index_i),
    .ident_i        (ident_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .served_ident_o (served_ident_o),
    .served_queue_o (served_queue_o),
    .best_queue_o   (best_queue_o),
    .best_count_o   (best_count_o)
  );

endmodule

// ----- hdl/mfsq_ctrl.sv -----
// Controller state machine for the multi-queue FIFO.
// Sequences decode, head read and compare, min scan and result hand-off.
// Depends on mfsq_pkg.
module mfsq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mfsq_pkg::dp_status_t dp_status_i,
  output mfsq_pkg::ctrl_cmd_t  cmd_o
);
  import mfsq_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (dp_status_i.req)
          REQ_ENQUEUE:  state_d = S_MIN;
          REQ_SERVE: begin
            if (!dp_status_i.qidx_ok || dp_status_i.occ_zero) state_d = S_MIN;
            else state_d = S_HEAD_RD;
          end
          REQ_CHECKOUT: state_d = S_HEAD_RD;
          REQ_QUERY:    state_d = S_MIN;
          default:      state_d = S_MIN;
        endcase
      end
      S_HEAD_RD: state_d = S_HEAD_CHK;
      S_HEAD_CHK: begin
        if (dp_status_i.req == REQ_SERVE ||
            (!dp_status_i.occ_zero && dp_status_i.head_match) ||
            dp_status_i.sel_last) begin
          state_d = S_MIN;
        end else begin
          state_d = S_HEAD_RD;
        end
      end
      S_MIN: begin
        if (dp_status_i.sel_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!dp_status_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_DECODE: begin
        unique case (dp_status_i.req)
          REQ_ENQUEUE: begin
            cmd_o.min_start = 1'b1;
            if (!dp_status_i.qidx_ok) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = STAT_INVALID;
            end else if (dp_status_i.occ_full) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = STAT_FULL;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
          REQ_SERVE: begin
            if (!dp_status_i.qidx_ok) begin
              cmd_o.min_start   = 1'b1;
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = STAT_INVALID;
            end else if (dp_status_i.occ_zero) begin
              cmd_o.min_start   = 1'b1;
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = STAT_EMPTY;
            end
          end
          REQ_CHECKOUT: ;
          REQ_QUERY:    cmd_o.min_start = 1'b1;
          default:      cmd_o.min_start = 1'b1;
        endcase
      end
      S_HEAD_RD: ;
      S_HEAD_CHK: begin
        if (dp_status_i.req == REQ_SERVE ||
            (!dp_status_i.occ_zero && dp_status_i.head_match)) begin
          cmd_o.pop       = 1'b1;
          cmd_o.min_start = 1'b1;
        end else if (dp_status_i.sel_last) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = STAT_NOT_FOUND;
          cmd_o.min_start   = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_MIN: begin
        cmd_o.min_step  = 1'b1;
        cmd_o.scan_next = !dp_status_i.sel_last;
      end
      S_DONE: begin
        cmd_o.out_load = !dp_status_i.out_busy;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !dp_status_i.out_busy) |=> (state_q == S_IDLE))
    else $error("result hand-off did not return to idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_DECODE))
    else $error("accepted beat not decoded");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HEAD_RD) |=> (state_q == S_HEAD_CHK))
    else $error("head read not followed by compare");
`endif

endmodule

// ----- hdl/mfsq_datapath.sv -----
// Datapath for the multi-queue FIFO: identifier memory, per-queue pointers
// and counts, request registers, min scan and output register.
// Depends on mfsq_pkg.
module mfsq_datapath #(
  parameter int unsigned NUM_QUEUES  = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16,
  localparam int unsigned QW = $clog2(NUM_QUEUES),
  localparam int unsigned PW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mfsq_pkg::ctrl_cmd_t              cmd_i,
  output mfsq_pkg::dp_status_t             dp_status_o,
  input  logic [mfsq_pkg::REQ_BITS-1:0]    req_type_i,
  input  logic [mfsq_pkg::QIDX_BITS-1:0]   queue_index_i,
  input  logic [ID_BITS-1:0]               ident_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mfsq_pkg::STATUS_BITS-1:0] status_o,
  output logic [ID_BITS-1:0]               served_ident_o,
  output logic [QW-1:0]                    served_queue_o,
  output logic [QW-1:0]                    best_queue_o,
  output logic [CW-1:0]                    best_count_o
);
  import mfsq_pkg::*;

  localparam int unsigned AW        = QW + PW;
  localparam int unsigned MEM_DEPTH = NUM_QUEUES * (2 ** PW);

  logic [ID_BITS-1:0] mem_q [MEM_DEPTH];
  logic [ID_BITS-1:0] rd_data_q;

  logic [PW-1:0] head_q [NUM_QUEUES];
  logic [PW-1:0] tail_q [NUM_QUEUES];
  logic [CW-1:0] occ_q  [NUM_QUEUES];
  logic [QW-1:0] sel_q;
  req_type_e     req_q;
  logic          qidx_ok_q;
  logic          out_valid_q;

  logic [ID_BITS-1:0] ident_q;
  status_e            status_q;
  logic [ID_BITS-1:0] served_ident_q;
  logic [QW-1:0]      served_queue_q;
  logic [QW-1:0]      best_q;
  logic [CW-1:0]      best_cnt_q;

  status_e            out_status_q;
  logic [ID_BITS-1:0] out_ident_q;
  logic [QW-1:0]      out_squeue_q;
  logic [QW-1:0]      out_best_q;
  logic [CW-1:0]      out_cnt_q;

  logic [PW-1:0] head_sel, tail_sel, head_nxt, tail_nxt;
  logic [CW-1:0] occ_sel;
  logic          qidx_ok;

  assign head_sel = head_q[sel_q];
  assign tail_sel = tail_q[sel_q];
  assign occ_sel  = occ_q[sel_q];
  assign head_nxt = (head_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + PW'(1);
  assign tail_nxt = (tail_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_sel + PW'(1);
  assign qidx_ok  = (int'(queue_index_i) < int'(NUM_QUEUES));

  assign dp_status_o.req        = req_q;
  assign dp_status_o.qidx_ok    = qidx_ok_q;
  assign dp_status_o.occ_zero   = (occ_sel == '0);
  assign dp_status_o.occ_full   = (occ_sel == CW'(QUEUE_DEPTH));
  assign dp_status_o.head_match = (rd_data_q == ident_q);
  assign dp_status_o.sel_last   = (sel_q == QW'(NUM_QUEUES - 1));
  assign dp_status_o.out_busy   = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[AW'({sel_q, tail_sel})] <= ident_q;
    end
    rd_data_q <= mem_q[AW'({sel_q, head_sel})];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        occ_q[i]  <= '0;
      end
      sel_q       <= '0;
      req_q       <= REQ_ENQUEUE;
      qidx_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        req_q     <= req_type_e'(req_type_i);
        qidx_ok_q <= qidx_ok;
        sel_q     <= (qidx_ok && (req_type_e'(req_type_i) == REQ_ENQUEUE ||
                                  req_type_e'(req_type_i) == REQ_SERVE))
                     ? QW'(queue_index_i) : '0;
      end else if (cmd_i.min_start) begin
        sel_q <= '0;
      end else if (cmd_i.scan_next) begin
        sel_q <= sel_q + QW'(1);
      end
      if (cmd_i.push) begin
        tail_q[sel_q] <= tail_nxt;
        occ_q[sel_q]  <= occ_sel + CW'(1);
      end
      if (cmd_i.pop) begin
        head_q[sel_q] <= head_nxt;
        occ_q[sel_q]  <= occ_sel - CW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ident_q        <= ident_i;
      status_q       <= STAT_OK;
      served_ident_q <= '0;
      served_queue_q <= '0;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
    if (cmd_i.pop) begin
      served_ident_q <= rd_data_q;
      served_queue_q <= sel_q;
    end
    if (cmd_i.min_step && (sel_q == '0 || occ_sel < best_cnt_q)) begin
      best_q     <= sel_q;
      best_cnt_q <= occ_sel;
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_ident_q  <= served_ident_q;
      out_squeue_q <= served_queue_q;
      out_best_q   <= best_q;
      out_cnt_q    <= best_cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign served_ident_o = out_ident_q;
  assign served_queue_o = out_squeue_q;
  assign best_queue_o   = out_best_q;
  assign best_count_o   = out_cnt_q;

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (occ_sel != '0))
    else $error("pop from an empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (qidx_ok_q && occ_sel != CW'(QUEUE_DEPTH)))
    else $error("push onto a full or invalid queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_sel <= CW'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for multi_fifo_shortest_queue_core: directed and random requests
// against an in-bench queue predictor, with random idle and stall on both channels.
// Depends on mfsq_pkg and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mfsq_pkg::*;

  localparam int unsigned NQ        = 4;
  localparam int unsigned DEPTH     = 16;
  localparam int unsigned IDW       = 16;
  localparam int unsigned LIMIT     = 1000000;
  localparam int unsigned CHUNK     = 120;
  localparam int unsigned NUM_CHUNK = 13;

  typedef struct {
    req_type_e      rq;
    logic [2:0]     qi;
    logic [IDW-1:0] id;
  } request_t;

  typedef struct packed {
    status_e        status;
    logic [IDW-1:0] served_ident;
    logic [1:0]     served_queue;
    logic [1:0]     best_queue;
    logic [4:0]     best_count;
  } ticket_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  logic [1:0]     req_type_i = '0;
  logic [2:0]     queue_index_i = '0;
  logic [IDW-1:0] ident_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  logic [2:0]     status_o;
  logic [IDW-1:0] served_ident_o;
  logic [1:0]     served_queue_o;
  logic [1:0]     best_queue_o;
  logic [4:0]     best_count_o;

  request_t       pending_reqs[$];
  ticket_t        due_tickets[$];
  logic [IDW-1:0] slot_mem[NQ][DEPTH];
  int unsigned    head_idx[NQ];
  int unsigned    tail_idx[NQ];
  int unsigned    fill_cnt[NQ];
  logic [IDW-1:0] id_pool[6];
  logic           calm = 1'b0;
  logic           req_taken = 1'b0;
  int unsigned    send_idle = 0;
  int unsigned    stall_left = 0;
  int unsigned    cycle_cnt = 0;
  int unsigned    fail_cnt = 0;

  multi_fifo_shortest_queue_core #(
    .NUM_QUEUES (NQ),
    .QUEUE_DEPTH(DEPTH),
    .ID_BITS    (IDW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .queue_index_i (queue_index_i),
    .ident_i       (ident_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .served_ident_o(served_ident_o),
    .served_queue_o(served_queue_o),
    .best_queue_o  (best_queue_o),
    .best_count_o  (best_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IDW-1:0] take_head(int unsigned q);
    logic [IDW-1:0] v;
    v = slot_mem[q][head_idx[q]];
    head_idx[q] = (head_idx[q] + 1 == DEPTH) ? 0 : head_idx[q] + 1;
    fill_cnt[q]--;
    return v;
  endfunction

  task automatic apply_request(req_type_e rq, logic [2:0] qi, logic [IDW-1:0] id);
    ticket_t     t;
    int unsigned q;
    int unsigned bq;
    q = int'(qi);
    bq = 0;
    t = '{status: STAT_OK, served_ident: '0, served_queue: '0, best_queue: '0,
          best_count: '0};
    case (rq)
      REQ_ENQUEUE: begin
        if (q >= NQ) t.status = STAT_INVALID;
        else if (fill_cnt[q] == DEPTH) t.status = STAT_FULL;
        else begin
          slot_mem[q][tail_idx[q]] = id;
          tail_idx[q] = (tail_idx[q] + 1 == DEPTH) ? 0 : tail_idx[q] + 1;
          fill_cnt[q]++;
        end
      end
      REQ_SERVE: begin
        if (q >= NQ) t.status = STAT_INVALID;
        else if (fill_cnt[q] == 0) t.status = STAT_EMPTY;
        else begin
          t.served_ident = take_head(q);
          t.served_queue = 2'(q);
        end
      end
      REQ_CHECKOUT: begin
        t.status = STAT_NOT_FOUND;
        for (int unsigned k = 0; k < NQ; k++) begin
          if (t.status == STAT_NOT_FOUND && fill_cnt[k] != 0 &&
              slot_mem[k][head_idx[k]] == id) begin
            t.served_ident = take_head(k);
            t.served_queue = 2'(k);
            t.status = STAT_OK;
          end
        end
      end
      default: ;
    endcase
    for (int unsigned k = 1; k < NQ; k++) begin
      if (fill_cnt[k] < fill_cnt[bq]) bq = k;
    end
    t.best_queue = 2'(bq);
    t.best_count = 5'(fill_cnt[bq]);
    due_tickets.push_back(t);
  endtask

  task automatic add_req(req_type_e rq, logic [2:0] qi, logic [IDW-1:0] id);
    request_t r;
    r.rq = rq;
    r.qi = qi;
    r.id = id;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(bit fill_mode);
    int unsigned    r;
    req_type_e      rq;
    logic [2:0]     qi;
    logic [IDW-1:0] id;
    r = $urandom_range(0, 99);
    if (fill_mode) begin
      if (r < 75) rq = REQ_ENQUEUE;
      else if (r < 85) rq = REQ_SERVE;
      else if (r < 95) rq = REQ_CHECKOUT;
      else rq = REQ_QUERY;
    end else begin
      if (r < 15) rq = REQ_ENQUEUE;
      else if (r < 65) rq = REQ_SERVE;
      else if (r < 92) rq = REQ_CHECKOUT;
      else rq = REQ_QUERY;
    end
    if ($urandom_range(0, 9) == 0) qi = 3'($urandom_range(4, 7));
    else qi = 3'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 7) id = id_pool[$urandom_range(0, 5)];
    else id = IDW'($urandom);
    add_req(rq, qi, id);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || due_tickets.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // accept request beats and predict
  always @(posedge clk_i) begin
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      apply_request(req_type_e'(req_type_i), queue_index_i, ident_i);
      void'(pending_reqs.pop_front());
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !req_taken) begin
    end else if (send_idle != 0) begin
      in_valid_i <= 1'b0;
      send_idle <= send_idle - 1;
    end else if (pending_reqs.size() != 0) begin
      in_valid_i    <= 1'b1;
      req_type_i    <= pending_reqs[0].rq;
      queue_index_i <= pending_reqs[0].qi;
      ident_i       <= pending_reqs[0].id;
      send_idle     <= pick_gap();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // result stall driver
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left <= pick_gap();
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_mon
    ticket_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_tickets.size() == 0) begin
        $error("unexpected result beat: status %0h ident %0h", status_o, served_ident_o);
        fail_cnt++;
      end else begin
        want = due_tickets.pop_front();
        check_field("status", want.status, status_o);
        check_field("served_ident", want.served_ident, served_ident_o);
        check_field("served_queue", want.served_queue, served_queue_o);
        check_field("best_queue", want.best_queue, best_queue_o);
        check_field("best_count", want.best_count, best_count_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("multi_fifo_shortest_queue_core test failed");
      $finish;
    end
  end

  initial begin
    for (int unsigned q = 0; q < NQ; q++) begin
      head_idx[q] = 0;
      tail_idx[q] = 0;
      fill_cnt[q] = 0;
    end
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < 6; i++) id_pool[i] = IDW'($urandom);
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    add_req(REQ_QUERY,    3'd0, 16'h0000);
    add_req(REQ_SERVE,    3'd0, 16'h0000);
    add_req(REQ_SERVE,    3'd7, 16'h0000);
    add_req(REQ_ENQUEUE,  3'd4, 16'hffff);
    add_req(REQ_CHECKOUT, 3'd0, 16'h0000);
    add_req(REQ_ENQUEUE,  3'd0, 16'h0000);
    add_req(REQ_ENQUEUE,  3'd1, 16'hffff);
    add_req(REQ_ENQUEUE,  3'd2, 16'h1234);
    add_req(REQ_ENQUEUE,  3'd3, 16'h8000);
    add_req(REQ_ENQUEUE,  3'd1, 16'habcd);
    add_req(REQ_ENQUEUE,  3'd3, 16'habcd);
    add_req(REQ_CHECKOUT, 3'd7, 16'hffff);
    add_req(REQ_CHECKOUT, 3'd0, 16'habcd);
    add_req(REQ_CHECKOUT, 3'd5, 16'habcd);
    add_req(REQ_SERVE,    3'd3, 16'h0000);
    add_req(REQ_CHECKOUT, 3'd2, 16'habcd);
    add_req(REQ_QUERY,    3'd6, 16'hffff);
    add_req(REQ_SERVE,    3'd0, 16'h0000);
    add_req(REQ_CHECKOUT, 3'd1, 16'h5555);
    add_req(REQ_SERVE,    3'd2, 16'h0000);
    wait_drained();

    for (int unsigned c = 0; c < NUM_CHUNK; c++) begin
      calm = (c % 4 == 3);
      for (int unsigned i = 0; i < CHUNK; i++) add_random(c % 2 == 0);
      if (c == NUM_CHUNK / 2) wait_drained();
    end
    calm = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("multi_fifo_shortest_queue_core test passed");
    end else begin
      $display("multi_fifo_shortest_queue_core test failed");
    end
    $finish;
  end

endmodule

// ----- multi_fifo_shortest_queue_core.f -----
hdl/mfsq_pkg.sv
hdl/mfsq_ctrl.sv
hdl/mfsq_datapath.sv
hdl/multi_fifo_shortest_queue_core.sv
dv/testbench.sv
